[hw/rtl/dtbc_pkg.sv]
// Shared types and constants for the decision tree branch counter.
// No dependencies.
package dtbc_pkg;

  typedef enum logic [2:0] {
    CMD_WR_NODE  = 3'd0,
    CMD_WR_FEAT  = 3'd1,
    CMD_EVAL     = 3'd2,
    CMD_RD_CNT   = 3'd3,
    CMD_CLR_CNT  = 3'd4,
    CMD_WR_ROOT  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_LT = 3'd0,
    OP_LE = 3'd1,
    OP_EQ = 3'd2,
    OP_GT = 3'd3,
    OP_GE = 3'd4
  } cmp_op_e;

  // Node and feature table sizes are tied to the 10-bit node fields and the 6-bit feature field.
  localparam int unsigned MaxNodes    = 1024;
  localparam int unsigned MaxFeatures = 64;
  localparam int unsigned MaxTrees    = 16;

  localparam int unsigned CntW = 48;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam int unsigned RegTreeCount = 0;

  // Payload of one command transfer.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [9:0]         index;
    logic [2:0]         node_flags;
    logic [5:0]         split_feature;
    logic [9:0]         default_child;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic [2:0]         compare_op;
    logic signed [31:0] value;
    logic [63:0]        category_set;
    logic               is_missing;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] count_value;
    logic            status;
  } rsp_t;

  // Numeric split test; unknown operators are false.
  function automatic logic cmp_eval(input logic signed [31:0] f, input logic [2:0] op,
                                    input logic signed [31:0] t);
    logic r;
    case (op)
      OP_LT:   r = f < t;
      OP_LE:   r = f <= t;
      OP_EQ:   r = f == t;
      OP_GT:   r = f > t;
      OP_GE:   r = f >= t;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dtbc_if.sv]
// Valid/ready channel interface carrying one payload.
// Depends on dtbc_pkg only through its users' type parameter.
interface dtbc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dtbc_walk.sv]
// Tree walk sequencer: node memories, counters and one shared split unit.
// Depends on dtbc_pkg.
module dtbc_walk #(
  parameter int unsigned MaxDepth    = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dtbc_pkg::req_t req_i,
  input  logic [4:0]     tree_count_i,
  output logic           busy_o,
  output logic           done_o,
  output dtbc_pkg::rsp_t rsp_o
);
  import dtbc_pkg::*;

  localparam int unsigned NW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned FW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned TW = (MaxTrees > 1) ? $clog2(MaxTrees) : 1;
  localparam int unsigned DW = $clog2(MaxDepth + 1);
  localparam int unsigned TCW = $clog2(MaxTrees + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RWAIT, S_ROOT, S_READ, S_FEAT, S_STEP, S_CLEAR, S_FCLR, S_DONE
  } state_e;

  logic [41:0]        links_mem [MaxNodes];
  logic signed [31:0] thr_mem   [MaxNodes];
  logic [63:0]        cat_mem   [MaxNodes];
  logic [CntW-1:0]    cnt_mem   [MaxNodes];
  logic [9:0]         root_mem  [MaxTrees];
  logic signed [31:0] feat_mem  [MaxFeatures];
  logic [MaxFeatures-1:0] absent_q;

  state_e          state_q;
  logic [10:0]     node_q;
  logic [DW-1:0]   steps_q;
  logic [TCW-1:0]  tree_q, ntree_q;
  logic [NW:0]     clr_q;
  logic            status_q;
  logic [CntW-1:0] count_q;
  logic            init_q;

  logic [41:0]        lk_r;
  logic signed [31:0] thr_r;
  logic [63:0]        cat_r;
  logic [CntW-1:0]    cnt_r;
  logic [9:0]         root_r;
  logic signed [31:0] fv_r;
  logic               fabs_r;

  // Shared split unit on the registered node word.
  logic [5:0]  feat_w;
  logic        miss_w, res_w, cat_hit_w;
  logic [15:0] cat_w;
  logic [9:0]  next_w;
  assign feat_w = lk_r[8:3];
  assign miss_w = (32'(feat_w) >= MaxFeatures) || fabs_r;
  assign cat_w  = fv_r[31:16];
  assign cat_hit_w = !fv_r[31] && (cat_w < 16'd64) && cat_r[cat_w[5:0]];
  always_comb begin
    if (lk_r[1]) res_w = cat_hit_w ^ lk_r[2];
    else         res_w = cmp_eval(fv_r, lk_r[41:39], thr_r);
    if (miss_w)     next_w = lk_r[18:9];
    else if (res_w) next_w = lk_r[28:19];
    else            next_w = lk_r[38:29];
  end

  logic in_node;
  assign in_node = 32'(node_q) < MaxNodes;

  // Memory ports: writes by command, counter clear or counter update, registered reads.
  // The feature read uses the registered node word, in the cycle after the node read.
  always_ff @(posedge clk_i) begin
    if (start_i && req_i.cmd == CMD_WR_NODE && 32'(req_i.index) < MaxNodes) begin
      links_mem[req_i.index[NW-1:0]] <= {req_i.compare_op, req_i.right_child,
          req_i.left_child, req_i.default_child, req_i.split_feature, req_i.node_flags};
      thr_mem[req_i.index[NW-1:0]] <= req_i.value;
      cat_mem[req_i.index[NW-1:0]] <= req_i.category_set;
    end
    if (start_i && req_i.cmd == CMD_WR_FEAT && 32'(req_i.index) < MaxFeatures)
      feat_mem[req_i.index[FW-1:0]] <= req_i.value;
    if (start_i && req_i.cmd == CMD_WR_ROOT && 32'(req_i.index) < MaxTrees)
      root_mem[req_i.index[TW-1:0]] <= req_i.left_child;
    if (state_q == S_CLEAR)
      cnt_mem[clr_q[NW-1:0]] <= '0;
    else if (state_q == S_STEP && steps_q < DW'(MaxDepth) && in_node)
      cnt_mem[node_q[NW-1:0]] <= (cnt_r == CntMax) ? cnt_r : cnt_r + 1'b1;
    lk_r   <= links_mem[node_q[NW-1:0]];
    thr_r  <= thr_mem[node_q[NW-1:0]];
    cat_r  <= cat_mem[node_q[NW-1:0]];
    cnt_r  <= cnt_mem[start_i ? req_i.index[NW-1:0] : node_q[NW-1:0]];
    root_r <= root_mem[tree_q[TW-1:0]];
    fv_r   <= feat_mem[lk_r[3+FW-1:3]];
    fabs_r <= absent_q[lk_r[3+FW-1:3]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      absent_q <= '1;
      node_q   <= '0;
      steps_q  <= '0;
      tree_q   <= '0;
      ntree_q  <= '0;
      clr_q    <= '0;
      status_q <= 1'b0;
      count_q  <= '0;
      init_q   <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            status_q <= 1'b0;
            count_q  <= '0;
            tree_q   <= '0;
            ntree_q  <= (32'(tree_count_i) > MaxTrees) ? TCW'(MaxTrees)
                                                       : TCW'(tree_count_i);
            case (req_i.cmd)
              CMD_WR_FEAT: begin
                if (32'(req_i.index) < MaxFeatures)
                  absent_q[req_i.index[FW-1:0]] <= req_i.is_missing;
                state_q <= S_DONE;
              end
              CMD_EVAL:    state_q <= S_RWAIT;
              CMD_RD_CNT: begin
                node_q  <= {1'b0, req_i.index};
                state_q <= S_FCLR;
              end
              CMD_CLR_CNT: begin
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default:     state_q <= S_DONE;
            endcase
          end
        end
        S_FCLR: begin
          // Counter read data is valid here.
          if (32'(node_q) < MaxNodes) count_q <= cnt_r;
          state_q <= S_DONE;
        end
        // The root table is read for the current tree_q during this cycle.
        S_RWAIT: state_q <= S_ROOT;
        S_ROOT: begin
          if (tree_q >= ntree_q) begin
            absent_q <= '1;
            state_q  <= S_DONE;
          end else begin
            node_q  <= {1'b0, root_r};
            steps_q <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_FEAT;
        S_FEAT: state_q <= S_STEP;
        S_STEP: begin
          if (!in_node || steps_q >= DW'(MaxDepth) || lk_r[0]) begin
            if (in_node && steps_q >= DW'(MaxDepth)) status_q <= 1'b1;
            tree_q  <= tree_q + 1'b1;
            state_q <= S_RWAIT;
          end else begin
            steps_q <= steps_q + 1'b1;
            node_q  <= {1'b0, next_w};
            state_q <= S_READ;
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          // The pass after reset gives no result; a clear command does.
          if (32'(clr_q) == MaxNodes - 1) begin
            init_q  <= 1'b0;
            state_q <= init_q ? S_IDLE : S_DONE;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;
  assign rsp_o  = '{count_value: count_q, status: status_q};

endmodule

[hw/rtl/decision_tree_branch_counter_unit.sv]
// Top level of the branch counter; depends on dtbc_pkg, dtbc_if and dtbc_walk.
// The result is valid after the command transfer and held until it is taken. An evaluation
// walks each of up to 16 trees from its root until a leaf, a node outside the table or the
// depth bound; a walk cut by the depth bound sets the status bit.
// One command at a time: input is taken again the cycle after the result transfer. After the
// asynchronous reset the visit counters of all nodes are cleared before input is taken.
module decision_tree_branch_counter_unit #(
  parameter int unsigned MaxDepth    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtbc_if.sink        req,
  dtbc_if.source      rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtbc_pkg::*;
  localparam logic AddrTreeCount = 1'(4 * RegTreeCount);
  logic [4:0] tree_count_q;
  logic busy, done;
  rsp_t r;
  logic full_q;
  rsp_t hold_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrTreeCount) ? {27'd0, tree_count_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tree_count_q <= 5'd1;
    else if (psel && penable && pwrite && paddr == AddrTreeCount)
      tree_count_q <= pwdata[4:0];
  end

  assign req.ready = !busy && !full_q;
  dtbc_walk #(.MaxDepth(MaxDepth)) u_walk (
    .clk_i, .rst_ni, .start_i(req.valid && req.ready), .req_i(req.data),
    .tree_count_i(tree_count_q), .busy_o(busy), .done_o(done), .rsp_o(r));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (done) full_q <= 1'b1;
    else if (rsp.ready) full_q <= 1'b0;
  end
  always_ff @(posedge clk_i) if (done) hold_q <= r;
  assign rsp.valid = full_q;
  assign rsp.data  = hold_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data));
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp.valid |-> !req.ready);
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> !full_q);
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready);
endmodule

[verif/tb_decision_tree_branch_counter_unit.sv]
// Self-checking testbench for decision_tree_branch_counter_unit. A forest is
// loaded over the command channel, and every response is checked against a
// predictor. Depends on dtbc_pkg, dtbc_if and the RTL of the unit.
module tb_decision_tree_branch_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dtbc_pkg::*;

  localparam int unsigned NumNodes = 1024;
  localparam int unsigned NumFeat  = 64;
  localparam int unsigned NumTrees = 16;
  localparam int unsigned DepthMax = 32;
  localparam int unsigned IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dtbc_if #(.T(req_t)) req ();
  dtbc_if #(.T(rsp_t)) rsp ();

  decision_tree_branch_counter_unit dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  req_t              node_tab   [NumNodes];
  logic signed [31:0] feat_val  [NumFeat];
  bit                feat_abs   [NumFeat];
  logic [9:0]        root_tab   [NumTrees];
  logic [CntW-1:0]   visits     [NumNodes];
  logic [4:0]        tree_cnt;

  rsp_t expected_rsp[$];
  int   fails = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Pool of node slots used by trees; together they toggle every index bit.
  function automatic logic [9:0] pool(input int unsigned i);
    logic [5:0] k;
    k = i[5:0];
    return {k, k[3:0]};
  endfunction

  function automatic bit split_true(input req_t n, input logic signed [31:0] fv);
    bit r;
    int cat;
    if (n.node_flags[1]) begin
      r = 1'b0;
      if (fv >= 0) begin
        cat = fv >>> 16;
        if (cat < 64) r = n.category_set[cat];
      end
      if (n.node_flags[2]) r = !r;
    end else begin
      case (n.compare_op)
        OP_LT:   r = fv < n.value;
        OP_LE:   r = fv <= n.value;
        OP_EQ:   r = fv == n.value;
        OP_GT:   r = fv > n.value;
        OP_GE:   r = fv >= n.value;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Walks one tree, counting visits; returns 1 when the depth bound is hit.
  function automatic bit walk_tree(input logic [9:0] start);
    logic [9:0] nd;
    int unsigned steps;
    req_t n;
    nd = start;
    steps = 0;
    while (1) begin
      if (steps >= DepthMax) return 1'b1;
      if (visits[nd] != CntMax) visits[nd] = visits[nd] + 1;
      steps++;
      n = node_tab[nd];
      if (n.node_flags[0]) return 1'b0;
      if (feat_abs[n.split_feature]) nd = n.default_child;
      else if (split_true(n, feat_val[n.split_feature])) nd = n.left_child;
      else nd = n.right_child;
    end
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t o;
    int unsigned ntrees;
    o = '0;
    case (r.cmd)
      CMD_WR_NODE: node_tab[r.index] = r;
      CMD_WR_FEAT: if (r.index < NumFeat) begin
        feat_val[r.index] = r.value;
        feat_abs[r.index] = r.is_missing;
      end
      CMD_EVAL: begin
        ntrees = (tree_cnt > NumTrees) ? NumTrees : tree_cnt;
        for (int unsigned t = 0; t < ntrees; t++)
          if (walk_tree(root_tab[t])) o.status = 1'b1;
        foreach (feat_abs[i]) feat_abs[i] = 1'b1;
      end
      CMD_RD_CNT:  o.count_value = visits[r.index];
      CMD_CLR_CNT: foreach (visits[i]) visits[i] = '0;
      CMD_WR_ROOT: if (r.index < NumTrees) root_tab[r.index] = r.left_child;
      default: ;
    endcase
    return o;
  endfunction

  // Offers one command; valid stays high unless the next one is delayed.
  task automatic send_cmd(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    do @(posedge clk_i); while (!req.ready);
    expected_rsp = {expected_rsp, predict_response(r)};
  endtask

  task automatic drain_and_idle();
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DepthMax * NumTrees + 20) @(posedge clk_i);
  endtask

  task automatic set_tree_count(input logic [4:0] v);
    drain_and_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[4:0] !== v) report_mismatch("tree_count readback", 64'(prdata), 64'(v));
    psel <= 1'b0; penable <= 1'b0;
    tree_cnt = v;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return {16'($urandom_range(70)), 16'($urandom)};
      3: return -$signed({16'($urandom_range(8)), 16'($urandom)});
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t node_cmd(input logic [9:0] idx, input logic [2:0] flags,
                                    input logic [5:0] feat, input logic [2:0] op,
                                    input logic signed [31:0] thr, input logic [9:0] dflt,
                                    input logic [9:0] lft, input logic [9:0] rgt);
    req_t r;
    r = '0;
    r.cmd = CMD_WR_NODE; r.index = idx; r.node_flags = flags; r.split_feature = feat;
    r.compare_op = op; r.value = thr; r.default_child = dflt; r.left_child = lft;
    r.right_child = rgt; r.category_set = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_simple(input cmd_e c, input logic [9:0] idx,
                             input logic signed [31:0] v, input logic miss,
                             input logic [9:0] lft);
    req_t r;
    r = '0;
    r.cmd = c; r.index = idx; r.value = v; r.is_missing = miss; r.left_child = lft;
    send_cmd(r);
  endtask

  function automatic req_t rand_cmd();
    req_t r;
    int sel;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    sel = $urandom_range(99);
    if (sel < 25) begin
      r.cmd = CMD_WR_NODE;
      r.index = pool($urandom_range(63));
      r.node_flags[0] = ($urandom_range(99) < 30);
      r.default_child = ($urandom_range(9) == 0) ? r.index : pool($urandom_range(63));
      r.left_child = pool($urandom_range(63));
      r.right_child = pool($urandom_range(63));
      r.value = rand_value();
      if ($urandom_range(3) == 0) r.category_set = $urandom_range(1) ? '1 : '0;
    end else if (sel < 60) begin
      r.cmd = CMD_WR_FEAT;
      r.index = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(NumFeat - 1));
      r.is_missing = ($urandom_range(3) == 0);
      r.value = rand_value();
    end else if (sel < 75) r.cmd = CMD_EVAL;
    else if (sel < 90) begin
      r.cmd = CMD_RD_CNT;
      if ($urandom_range(1)) r.index = pool($urandom_range(63));
    end else if (sel < 92) r.cmd = CMD_CLR_CNT;
    else if (sel < 97) begin
      r.cmd = CMD_WR_ROOT;
      r.index = 10'($urandom_range(31));
      r.left_child = pool($urandom_range(63));
    end else r.cmd = cmd_e'(3'($urandom_range(6, 7)));
    return r;
  endfunction

  // Every pool node and every root is written before any walk can reach them.
  task automatic test_forest_load();
    for (int i = 0; i < 64; i++)
      send_cmd(node_cmd(pool(i), 3'b001, 6'd0, OP_LT, 0, pool(0), pool(0), pool(0)));
    for (int t = 0; t < NumTrees; t++) send_simple(CMD_WR_ROOT, 10'(t), 0, 1'b0, pool(t));
  endtask

  // Root 0 tests one split with both leaves below it.
  task automatic test_splits();
    logic signed [31:0] thr;
    for (int op = 0; op < 8; op++) begin
      thr = (op == 0) ? 32'sh8000_0000 : (op == 7) ? 32'sh7fff_ffff : 32'sh0001_0000;
      send_cmd(node_cmd(pool(0), 3'b000, 6'd63, 3'(op), thr, pool(1), pool(2), pool(3)));
      send_simple(CMD_WR_FEAT, 10'd63, (op % 2) ? thr : thr + 1, 1'b0, '0);
      send_simple(CMD_EVAL, '0, 0, 1'b0, '0);
      send_simple(CMD_RD_CNT, pool(2), 0, 1'b0, '0);
    end
    // Categorical with and without inversion, negative and too-large categories.
    foreach (node_tab[i]) ;
    for (int k = 0; k < 4; k++) begin
      send_cmd(node_cmd(pool(0), {k[0], 2'b10}, 6'd5, OP_LT, 0, pool(1), pool(2), pool(3)));
      send_simple(CMD_WR_FEAT, 10'd5, (k < 2) ? {16'(k * 40 + 3), 16'h8000}
                  : (k == 2) ? -32'sd65536 : 32'sh0040_0000, 1'b0, '0);
      send_simple(CMD_EVAL, '0, 0, 1'b0, '0);
    end
    // Missing feature loops on itself until the depth bound is hit.
    send_cmd(node_cmd(pool(0), 3'b000, 6'd7, OP_EQ, 0, pool(0), pool(2), pool(3)));
    send_simple(CMD_EVAL, '0, 0, 1'b0, '0);
    send_simple(CMD_RD_CNT, pool(0), 0, 1'b0, '0);
    send_cmd(node_cmd(pool(0), 3'b001, 6'd0, OP_LT, 0, pool(0), pool(0), pool(0)));
  endtask

  task automatic test_edge_cmds();
    send_simple(CMD_WR_FEAT, 10'd1023, 32'sh7fff_ffff, 1'b0, '0);
    send_simple(CMD_WR_ROOT, 10'd1023, 0, 1'b0, 10'h3ff);
    send_simple(CMD_RD_CNT, 10'd1023, 0, 1'b0, '0);
    send_simple(cmd_e'(3'd6), '0, 0, 1'b0, '0);
    send_simple(cmd_e'(3'd7), '0, 0, 1'b0, '0);
    send_simple(CMD_CLR_CNT, '0, 0, 1'b0, '0);
    send_simple(CMD_RD_CNT, pool(0), 0, 1'b0, '0);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_cmd(rand_cmd());
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_cmd(rand_cmd());
  endtask

  // Response side: ready pattern, long hold-off and field checks.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected response", 64'(rsp.data), 64'd0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.data.count_value !== want.count_value)
          report_mismatch("count_value", 64'(rsp.data.count_value),
                          64'(want.count_value));
        if (rsp.data.status !== want.status)
          report_mismatch("status", 64'(rsp.data.status), 64'(want.status));
      end
    end
    if (hold_req) begin
      hold_left = 600;
      hold_req = 1'b0;
    end
    if (hold_left > 0) hold_left--;
    rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("tb_decision_tree_branch_counter_unit: FAIL");
      $finish;
    end
  end

  initial begin
    foreach (feat_abs[i]) feat_abs[i] = 1'b1;
    foreach (visits[i]) visits[i] = '0;
    tree_cnt = 5'd1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_forest_load();
    test_splits();
    test_edge_cmds();
    set_tree_count(5'd16);
    test_random(200, 0, 0);
    set_tree_count(5'd1);
    test_random(200, 79, 0);
    set_tree_count(5'd31);
    test_random(200, 0, 79);
    test_backpressure();
    set_tree_count(5'd0);
    test_random(100, 31, 31);
    set_tree_count(5'($urandom_range(2, 15)));
    test_random(300, 0, 0);
    drain_and_idle();
    if (fails == 0) $display("tb_decision_tree_branch_counter_unit: PASS");
    else $display("tb_decision_tree_branch_counter_unit: FAIL");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/dtbc_pkg.sv
hw/rtl/dtbc_if.sv
hw/rtl/dtbc_walk.sv
hw/rtl/decision_tree_branch_counter_unit.sv
verif/tb_decision_tree_branch_counter_unit.sv
